>>> src/adaptive_running_average_unit_defines.svh
// Assertion macros shared by the running-average RTL.
`ifndef ADAPTIVE_RUNNING_AVERAGE_UNIT_DEFINES_SVH
`define ADAPTIVE_RUNNING_AVERAGE_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define ARAU_ASSERT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ARAU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/arau_pkg.sv
// Shared types and constants of the adaptive running-average unit.
package arau_pkg;

  localparam int unsigned FracBitsDef       = 8;
  localparam int unsigned WeightFracBitsDef = 16;

  localparam int unsigned SampleW = 24;
  localparam int unsigned AvgW    = 32;
  localparam int unsigned WeightW = 32;
  localparam int unsigned WholeW  = 16;
  localparam int unsigned RateW   = 16;
  localparam int unsigned TimeW   = 24;
  localparam int unsigned ThrW    = 24;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgW    = 32;
  localparam int unsigned MulBW   = 32;
  localparam int unsigned QuotW   = 32;
  localparam int unsigned OutDataW = 80;

  localparam logic [RateW-1:0] RateRst = RateW'(1);
  localparam logic [ThrW-1:0]  FastRst = ThrW'(1000);
  localparam logic [ThrW-1:0]  SlowRst = ThrW'(10);
  localparam int unsigned      LongRstInt  = 30;
  localparam int unsigned      ShortRstInt = 2;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SAMPLE_RATE = 3'd0,
    CFG_LONG_TIME   = 3'd1,
    CFG_SHORT_TIME  = 3'd2,
    CFG_FAST_THR    = 3'd3,
    CFG_SLOW_THR    = 3'd4,
    CFG_INIT_AVG    = 3'd5
  } cfg_idx_e;

  typedef enum logic [3:0] {
    S_IDLE, S_SR, S_LR, S_TOP, S_WSEL, S_IM, S_ID, S_WX,
    S_P4, S_P5, S_P6, S_DV, S_OUT
  } state_e;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_sts_t;

endpackage

>>> src/arau_mul.sv
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
module arau_mul import arau_pkg::*; #(
  parameter int unsigned A_W = 56,
  parameter int unsigned B_W = MulBW
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [A_W-1:0]     a_i,
  input  logic [B_W-1:0]     b_i,
  output unit_sts_t          sts_o,
  output logic [A_W+B_W-1:0] prod_o
);

  localparam int unsigned CntW = (B_W > 1) ? $clog2(B_W) : 1;

  logic [A_W-1:0]     mcand_q;
  logic [A_W+B_W-1:0] acc_q, acc_d;
  logic [A_W:0]       sum;
  logic [CntW-1:0]    cnt_q;
  logic               busy_q, done_q;

  always_comb begin
    sum   = {1'b0, acc_q[A_W+B_W-1:B_W]} + (acc_q[0] ? {1'b0, mcand_q} : '0);
    acc_d = {sum, acc_q[B_W-1:1]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(B_W - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      mcand_q <= a_i;
      acc_q   <= {{A_W{1'b0}}, b_i};
    end else if (busy_q) begin
      acc_q <= acc_d;
    end
  end

  assign prod_o = acc_q;
  assign sts_o  = '{busy: busy_q, done: done_q};

endmodule

>>> src/arau_div.sv
// Bit-serial restoring divider with 32-bit saturated quotient.
module arau_div import arau_pkg::*; #(
  parameter int unsigned N_W = 89,
  parameter int unsigned D_W = 48
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [N_W-1:0]   num_i,
  input  logic [D_W-1:0]   den_i,
  output unit_sts_t        sts_o,
  output logic [QuotW-1:0] quot_o
);

  localparam int unsigned CntW = $clog2(N_W);

  logic [N_W-1:0]   num_q;
  logic [D_W-1:0]   den_q, rem_q, rem_d;
  logic [D_W:0]     r2, diff;
  logic             ge;
  logic [QuotW-1:0] q_q;
  logic             ovf_q;
  logic [CntW-1:0]  cnt_q;
  logic             busy_q, done_q;

  always_comb begin
    r2    = {rem_q, num_q[N_W-1]};
    ge    = r2 >= {1'b0, den_q};
    diff  = r2 - {1'b0, den_q};
    rem_d = ge ? diff[D_W-1:0] : r2[D_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(N_W - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
      q_q   <= '0;
      ovf_q <= 1'b0;
    end else if (busy_q) begin
      num_q <= {num_q[N_W-2:0], 1'b0};
      rem_q <= rem_d;
      ovf_q <= ovf_q | q_q[QuotW-1];
      q_q   <= {q_q[QuotW-2:0], ge};
    end
  end

  assign quot_o = ovf_q ? '1 : q_q;
  assign sts_o  = '{busy: busy_q, done: done_q};

endmodule

>>> src/adaptive_running_average_unit.sv
// Top level: adaptive running average with bit-serial multiply and divide.
//
// channel   dir  handshake                     payload
// s_axis    in   s_axis_tvalid_i/tready_o      tdata: sample
// m_axis    out  m_axis_tvalid_o/tready_i      tdata: average, weight, whole_sample; tuser: fault
// cfg       in   cfg_valid_i/cfg_ready_o       cfg_index_i, cfg_data_i
//
// One item runs through up to six multiplies of 32 multiplier bits and three
// divides of 89 numerator bits on one shared multiplier and one divider.
// Reset loads the register defaults; there is no clearing pass.
// A stalled output holds in its register; the next item is taken meanwhile.
module adaptive_running_average_unit import arau_pkg::*; #(
  parameter int unsigned FRAC_BITS        = FracBitsDef,
  parameter int unsigned WEIGHT_FRAC_BITS = WeightFracBitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  logic [SampleW-1:0]  s_axis_tdata_i,   // [23:0] sample
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  output logic [OutDataW-1:0] m_axis_tdata_o,   // [31:0] average, [63:32] weight,
                                                // [79:64] whole_sample
  output logic                m_axis_tuser_o,   // [0] fault
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgW-1:0]     cfg_data_i
);

  `include "adaptive_running_average_unit_defines.svh"

  localparam int unsigned NqW   = AvgW + WEIGHT_FRAC_BITS;
  localparam int unsigned McW   = (NqW > WeightW + SampleW) ? NqW : WeightW + SampleW;
  localparam int unsigned PW    = McW + MulBW;
  localparam int unsigned DnW   = PW + 1;
  localparam int unsigned LimW  = ThrW + FRAC_BITS;
  localparam int unsigned CmpW  = (LimW > AvgW) ? LimW : AvgW;

  localparam logic [WeightW-1:0] One = WeightW'(1) << WEIGHT_FRAC_BITS;

  state_e state_q, state_d;

  logic [RateW-1:0]   rate_q;
  logic [TimeW-1:0]   long_q, short_q;
  logic [ThrW-1:0]    fast_q, slow_q;
  logic [AvgW-1:0]    avg_q, n_q, top_q;
  logic [WeightW-1:0] w_q;
  logic               cond_q, ge_q;
  logic [PW-1:0]      a_q;
  logic [SampleW-1:0] sample_q;
  logic               m_valid_q;
  logic [OutDataW-1:0] m_data_q;
  logic               m_fault_q;

  logic               s_acc, out_free;
  logic               mul_start, div_start;
  logic [McW-1:0]     mul_a;
  logic [MulBW-1:0]   mul_b;
  logic [PW-1:0]      prod;
  logic [DnW-1:0]     div_num;
  logic [NqW-1:0]     div_den;
  logic [QuotW-1:0]   quot;
  unit_sts_t          mul_sts, div_sts;

  logic [PW-1:0]      prod_sh;
  logic [AvgW-1:0]    n_sat, nm1, top_alt;
  logic [CmpW-1:0]    avg_c, slow_lim, fast_lim;
  logic               low_w, high_w;
  logic [WeightW-1:0] top_dif, w_interp;
  logic [NqW-1:0]     nq, nq_dif;
  logic [DnW-1:0]     a_ext, b_ext;
  logic               neg;

  assign s_acc    = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free = !m_valid_q || m_axis_tready_i;

  // datapath helpers
  always_comb begin
    prod_sh  = prod >> FRAC_BITS;
    n_sat    = (|prod_sh[PW-1:AvgW]) ? '1 : prod_sh[AvgW-1:0];
    nm1      = n_sat - 1'b1;
    top_alt  = ((nm1 >> (AvgW - WEIGHT_FRAC_BITS)) != '0) ? '1 : (nm1 << WEIGHT_FRAC_BITS);
    avg_c    = CmpW'(avg_q);
    slow_lim = CmpW'(slow_q) << FRAC_BITS;
    fast_lim = CmpW'(fast_q) << FRAC_BITS;
    low_w    = avg_c <= slow_lim;
    high_w   = avg_c > fast_lim;
    top_dif  = (top_q >= One) ? (top_q - One) : (One - top_q);
    w_interp = (top_q >= One) ? (One + quot) : (One - quot);
    nq       = {n_q, {WEIGHT_FRAC_BITS{1'b0}}};
    nq_dif   = (nq >= NqW'(w_q)) ? (nq - NqW'(w_q)) : (NqW'(w_q) - nq);
    a_ext    = DnW'(a_q);
    b_ext    = DnW'(prod);
    neg      = !ge_q && (a_ext < b_ext);
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (s_acc) state_d = S_SR;
      S_SR:   if (mul_sts.done) state_d = S_LR;
      S_LR: begin
        if (mul_sts.done) begin
          if (n_sat == '0) state_d = S_OUT;
          else if (cond_q) state_d = S_TOP;
          else state_d = S_WSEL;
        end
      end
      S_TOP:  if (div_sts.done) state_d = S_WSEL;
      S_WSEL: state_d = (low_w || high_w) ? S_WX : S_IM;
      S_IM:   if (mul_sts.done) state_d = S_ID;
      S_ID:   if (div_sts.done) state_d = S_WX;
      S_WX:   state_d = S_P4;
      S_P4:   if (mul_sts.done) state_d = S_P5;
      S_P5:   if (mul_sts.done) state_d = S_P6;
      S_P6:   if (mul_sts.done) state_d = neg ? S_OUT : S_DV;
      S_DV:   if (div_sts.done) state_d = S_OUT;
      S_OUT:  if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // unit launches and operands, chosen by the state being entered
  always_comb begin
    mul_start = 1'b0;
    div_start = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    div_num   = '0;
    div_den   = '0;
    case (state_d)
      S_SR: begin
        mul_start = state_q != S_SR;
        mul_a     = McW'(short_q);
        mul_b     = MulBW'(rate_q);
      end
      S_LR: begin
        mul_start = state_q != S_LR;
        mul_a     = McW'(long_q);
        mul_b     = MulBW'(rate_q);
      end
      S_TOP: begin
        div_start = state_q != S_TOP;
        div_num   = DnW'(long_q) << WEIGHT_FRAC_BITS;
        div_den   = NqW'(short_q);
      end
      S_IM: begin
        mul_start = state_q != S_IM;
        mul_a     = McW'(top_dif);
        mul_b     = MulBW'(avg_q);
      end
      S_ID: begin
        div_start = state_q != S_ID;
        div_num   = DnW'(prod);
        div_den   = NqW'(fast_lim);
      end
      S_P4: begin
        mul_start = state_q != S_P4;
        mul_a     = McW'(w_q);
        mul_b     = MulBW'(sample_q);
      end
      S_P5: begin
        mul_start = state_q != S_P5;
        mul_a     = prod[McW-1:0];
        mul_b     = MulBW'(rate_q);
      end
      S_P6: begin
        mul_start = state_q != S_P6;
        mul_a     = McW'(nq_dif);
        mul_b     = MulBW'(avg_q);
      end
      S_DV: begin
        div_start = state_q != S_DV;
        div_num   = ge_q ? (a_ext + b_ext) : (a_ext - b_ext);
        div_den   = nq;
      end
      default: ;
    endcase
  end

  arau_mul #(.A_W(McW), .B_W(MulBW)) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .sts_o   (mul_sts),
    .prod_o  (prod)
  );

  arau_div #(.N_W(DnW), .D_W(NqW)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .sts_o   (div_sts),
    .quot_o  (quot)
  );

  // control, configuration and running state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      rate_q    <= RateRst;
      long_q    <= TimeW'(LongRstInt) << FRAC_BITS;
      short_q   <= TimeW'(ShortRstInt) << FRAC_BITS;
      fast_q    <= FastRst;
      slow_q    <= SlowRst;
      avg_q     <= AvgW'(1) << FRAC_BITS;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_SAMPLE_RATE: rate_q  <= cfg_data_i[RateW-1:0];
          CFG_LONG_TIME:   long_q  <= cfg_data_i[TimeW-1:0];
          CFG_SHORT_TIME:  short_q <= cfg_data_i[TimeW-1:0];
          CFG_FAST_THR:    fast_q  <= cfg_data_i[ThrW-1:0];
          CFG_SLOW_THR:    slow_q  <= cfg_data_i[ThrW-1:0];
          CFG_INIT_AVG:    avg_q   <= cfg_data_i[AvgW-1:0];
          default: ;
        endcase
      end
      if (state_q == S_P6 && mul_sts.done && neg) avg_q <= '0;
      if (state_q == S_DV && div_sts.done) avg_q <= quot;
      if (state_q == S_OUT && out_free) m_valid_q <= 1'b1;
      else if (m_axis_tready_i) m_valid_q <= 1'b0;
    end
  end

  // per-item working registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: if (s_acc) sample_q <= s_axis_tdata_i;
      S_SR:   if (mul_sts.done) cond_q <= prod > (PW'(1) << FRAC_BITS);
      S_LR: begin
        if (mul_sts.done) begin
          n_q <= n_sat;
          if (!cond_q) top_q <= top_alt;
        end
      end
      S_TOP:  if (div_sts.done) top_q <= quot;
      S_WSEL: begin
        if (low_w) w_q <= One;
        else if (high_w) w_q <= top_q;
      end
      S_ID:   if (div_sts.done) w_q <= w_interp;
      S_P5: begin
        if (mul_sts.done) begin
          a_q  <= prod;
          ge_q <= nq >= NqW'(w_q);
        end
      end
      S_OUT: begin
        if (out_free) begin
          m_fault_q <= n_q == '0;
          m_data_q  <= {WholeW'(sample_q >> FRAC_BITS),
                        (n_q == '0) ? '0 : w_q,
                        avg_q};
        end
      end
      default: ;
    endcase
  end

  assign s_axis_tready_o = state_q == S_IDLE;
  assign cfg_ready_o     = state_q == S_IDLE;
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tuser_o  = m_fault_q;

  `ARAU_ASSERT(a_fault_no_weight, m_axis_tvalid_o && m_axis_tuser_o, m_axis_tdata_o[63:32] == '0, "fault result carries a weight")
  `ARAU_ASSERT_NEXT(a_one_at_a_time, s_acc, !s_axis_tready_o, "second item taken while busy")
  `ARAU_ASSERT(a_mul_free, mul_start, !mul_sts.busy, "multiplier restarted while busy")
  `ARAU_ASSERT_NEXT(a_out_load, state_q == S_OUT && out_free, m_axis_tvalid_o, "result not presented")

endmodule

>>> sim/testbench.sv
// Self-checking testbench of the adaptive running-average unit.
module testbench;
  import arau_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Frac  = FracBitsDef;
  localparam int unsigned WFrac = WeightFracBitsDef;
  localparam logic [CfgIdxW-1:0] CfgUnusedLo = CfgIdxW'(6);
  localparam logic [CfgIdxW-1:0] CfgUnusedHi = CfgIdxW'(7);
  localparam longint unsigned CycleLimit = 4000000;
  localparam logic [127:0] Max32 = 128'hFFFF_FFFF;

  typedef struct packed {
    logic [WholeW-1:0]  whole;
    logic [WeightW-1:0] weight;
    logic [AvgW-1:0]    average;
    logic               fault;
  } avg_result_t;

  class avg_scoreboard;
    logic [RateW-1:0] rate;
    logic [TimeW-1:0] long_q8, short_q8;
    logic [ThrW-1:0]  fast_thr, slow_thr;
    logic [AvgW-1:0]  avg_now;
    logic [31:0]      count_n;
    avg_result_t      expected_q[$];
    int unsigned      errors;

    function new();
      rate = RateRst; long_q8 = TimeW'(LongRstInt << Frac);
      short_q8 = TimeW'(ShortRstInt << Frac); fast_thr = FastRst; slow_thr = SlowRst;
      avg_now = AvgW'(1 << Frac); errors = 0;
      update_count();
    endfunction

    function void update_count();
      logic [127:0] n;
      n = (128'(long_q8) * 128'(rate)) >> Frac;
      count_n = (n > Max32) ? 32'hFFFF_FFFF : n[31:0];
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] val);
      case (idx)
        CFG_SAMPLE_RATE: begin rate = val[RateW-1:0]; update_count(); end
        CFG_LONG_TIME:   begin long_q8 = val[TimeW-1:0]; update_count(); end
        CFG_SHORT_TIME:  short_q8 = val[TimeW-1:0];
        CFG_FAST_THR:    fast_thr = val[ThrW-1:0];
        CFG_SLOW_THR:    slow_thr = val[ThrW-1:0];
        CFG_INIT_AVG:    avg_now = val;
        default: ;
      endcase
    endfunction

    function void note_sample(logic [SampleW-1:0] smp);
      avg_result_t r;
      logic [127:0] one, top, w, av, nq, a, b, num, den, q;
      r.whole = smp[Frac +: WholeW];
      one = 128'(1) << WFrac;
      av = 128'(avg_now);
      if (count_n == 0) begin
        r.average = avg_now; r.weight = '0; r.fault = 1'b1;
      end else begin
        if (128'(short_q8) * 128'(rate) > (128'(1) << Frac))
          top = (128'(long_q8) << WFrac) / 128'(short_q8);
        else
          top = (128'(count_n) - 1) << WFrac;
        if (top > Max32) top = Max32;
        den = 128'(fast_thr) << Frac;
        if (av <= (128'(slow_thr) << Frac)) w = one;
        else if (av > den) w = top;
        else if (top >= one) w = one + ((top - one) * av) / den;
        else w = one - ((one - top) * av) / den;
        nq = 128'(count_n) << WFrac;
        a = ((w * 128'(smp)) & 128'hFFFF_FFFF_FFFF_FFFF) * 128'(rate);
        if (nq >= w) begin
          num = a + (nq - w) * av;
          q = num / nq;
        end else begin
          b = (w - nq) * av;
          q = (a < b) ? 128'(0) : (a - b) / nq;
        end
        if (q > Max32) q = Max32;
        avg_now = q[31:0];
        r.average = avg_now; r.weight = w[31:0]; r.fault = 1'b0;
      end
      expected_q.push_back(r);
    endfunction

    function void check_result(logic [OutDataW-1:0] data, logic user);
      avg_result_t e;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result data=%h fault=%b", $realtime, data, user);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      if (data[31:0] !== e.average) begin
        $display("%0t: average exp %h got %h", $realtime, e.average, data[31:0]);
        errors++;
      end
      if (data[63:32] !== e.weight) begin
        $display("%0t: weight exp %h got %h", $realtime, e.weight, data[63:32]);
        errors++;
      end
      if (data[79:64] !== e.whole) begin
        $display("%0t: whole_sample exp %h got %h", $realtime, e.whole, data[79:64]);
        errors++;
      end
      if (user !== e.fault) begin
        $display("%0t: fault exp %b got %b", $realtime, e.fault, user);
        errors++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                clk_i, rst_ni;
  logic                s_axis_tvalid_i, s_axis_tready_o;
  logic [SampleW-1:0]  s_axis_tdata_i;
  logic                m_axis_tvalid_o, m_axis_tready_i;
  logic [OutDataW-1:0] m_axis_tdata_o;
  logic                m_axis_tuser_o;
  logic                cfg_valid_i, cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgW-1:0]     cfg_data_i;

  avg_scoreboard   sb = new();
  longint unsigned cycles = 0;

  adaptive_running_average_unit u_dut (.*);

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i)
      sb.check_result(m_axis_tdata_o, m_axis_tuser_o);
  end

  // receiver stall pattern: always ready, random, or periodic stretches
  initial begin
    int mode, len;
    m_axis_tready_i = 1'b0;
    forever begin
      mode = $urandom_range(0, 2);
      len = $urandom_range(20, 400);
      for (int i = 0; i < len; i++) begin
        @(posedge clk_i);
        case (mode)
          0: m_axis_tready_i <= 1'b1;
          1: m_axis_tready_i <= ($urandom_range(0, 3) != 0);
          default: m_axis_tready_i <= ((i % 7) < 4);
        endcase
      end
    end
  end

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_reg(idx, val);
  endtask

  task automatic set_all(logic [31:0] rate, logic [31:0] lng, logic [31:0] sht,
                         logic [31:0] fst, logic [31:0] slw, logic [31:0] init);
    write_reg(CFG_SAMPLE_RATE, rate);
    write_reg(CFG_LONG_TIME, lng);
    write_reg(CFG_SHORT_TIME, sht);
    write_reg(CFG_FAST_THR, fst);
    write_reg(CFG_SLOW_THR, slw);
    write_reg(CFG_INIT_AVG, init);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic drain();
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  int burst_left = 0;

  task automatic send_sample(logic [SampleW-1:0] smp);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
      if (gap > 0) begin
        s_axis_tvalid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= smp;
    do @(posedge clk_i); while (!s_axis_tready_o);
    sb.note_sample(smp);
  endtask

  function automatic logic [SampleW-1:0] rand_sample();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return SampleW'($urandom_range(0, 2000) << Frac);
      3: return SampleW'($urandom_range(0, 4000));
      default: return SampleW'($urandom);
    endcase
  endfunction

  task automatic random_config();
    logic [31:0] rate, lng, sht, fst, slw, init;
    case ($urandom_range(0, 9))
      0: rate = 0;
      1, 2: rate = $urandom_range(1, 65535);
      default: rate = $urandom_range(1, 10);
    endcase
    case ($urandom_range(0, 9))
      0: lng = 0;
      1, 2: lng = $urandom & 32'hFF_FFFF;
      default: lng = $urandom_range(1, 60 << Frac);
    endcase
    sht = ($urandom_range(0, 3) == 0) ? ($urandom & 32'hFF_FFFF) : $urandom_range(0, 8 << Frac);
    fst = ($urandom_range(0, 4) == 0) ? ($urandom & 32'hFF_FFFF) : $urandom_range(0, 2000);
    slw = ($urandom_range(0, 4) == 0) ? ($urandom & 32'hFF_FFFF) : $urandom_range(0, fst);
    init = ($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(0, 3000 << Frac);
    set_all(rate, lng, sht, fst, slw, init);
  endtask

  initial begin
    rst_ni = 1'b0;
    s_axis_tvalid_i = 1'b0; s_axis_tdata_i = '0;
    cfg_valid_i = 1'b0; cfg_index_i = CFG_SAMPLE_RATE; cfg_data_i = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings, field extremes, climb past the fast threshold
    send_sample('0);
    send_sample('1);
    send_sample(SampleW'(1 << Frac));
    send_sample(SampleW'(5000 << Frac));
    send_sample(SampleW'(5000 << Frac));
    s_axis_tvalid_i <= 1'b0;
    drain();
    // huge update saturates to all ones
    set_all(65535, 32'hFF_FFFF, 0, 0, 0, 32'hFFFF_FF00);
    send_sample('1);
    send_sample('1);
    s_axis_tvalid_i <= 1'b0;
    drain();
    // zero speed count via zero rate, then via zero long time
    set_all(0, 30 << Frac, 2 << Frac, 1000, 10, 32'h1234);
    send_sample(SampleW'(7 << Frac));
    s_axis_tvalid_i <= 1'b0;
    drain();
    set_all(1, 0, 2 << Frac, 1000, 10, 32'h1234);
    send_sample(SampleW'(9 << Frac));
    s_axis_tvalid_i <= 1'b0;
    drain();
    // top weight above count with zero sample: negative result saturates to zero
    set_all(1, 384, 257, 0, 0, 32'hFFFF_FF00);
    send_sample('0);
    send_sample(SampleW'(3 << Frac));
    s_axis_tvalid_i <= 1'b0;
    drain();
    // long shorter than short: interpolation runs downward
    set_all(1, 1 << Frac, 2 << Frac, 1000, 0, 500 << Frac);
    send_sample(SampleW'(400 << Frac));
    send_sample(SampleW'(10 << Frac));
    s_axis_tvalid_i <= 1'b0;
    drain();
    // N of one with short*rate at most one
    set_all(1, 1 << Frac, 1 << Frac, 1000, 0, 200 << Frac);
    send_sample(SampleW'(100 << Frac));
    s_axis_tvalid_i <= 1'b0;
    drain();
    // unknown indexes are ignored
    write_reg(CfgUnusedLo, 32'hFFFF_FFFF);
    write_reg(CfgUnusedHi, 32'h0);
    cfg_valid_i <= 1'b0;
    send_sample(SampleW'(50 << Frac));
    send_sample(SampleW'($urandom));
    s_axis_tvalid_i <= 1'b0;
    drain();

    for (int ph = 0; ph < 25; ph++) begin
      random_config();
      for (int i = 0; i < 50; i++) begin
        if (ph == 3 && i == 25) begin
          s_axis_tvalid_i <= 1'b0;
          burst_left = 0;
          while (sb.pending() != 0) @(posedge clk_i);
        end
        send_sample(rand_sample());
      end
      s_axis_tvalid_i <= 1'b0;
      burst_left = 0;
      drain();
    end

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (600) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end
endmodule
